@@ hdl/bnf_pkg.sv @@
`default_nettype none

package bnf_pkg;

  localparam int MAP_BYTES_DEF = 128;

  localparam int CmdW   = 2;
  localparam int IndexW = 7;
  localparam int ByteW  = 8;
  localparam int BlockW = 10;

  localparam logic [CmdW-1:0] CMD_WRITE = 2'd0;
  localparam logic [CmdW-1:0] CMD_READ  = 2'd1;
  localparam logic [CmdW-1:0] CMD_ALLOC = 2'd2;

  typedef struct packed {
    logic [BlockW-1:0] block_number;
    logic              failed;
    logic [ByteW-1:0]  read_byte;
  } res_t;

endpackage

`default_nettype wire

@@ hdl/bnf_ram.sv @@
`default_nettype none

module bnf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hdl/bnf_ctrl.sv @@
`default_nettype none

module bnf_ctrl #(
  parameter int MAP_BYTES = bnf_pkg::MAP_BYTES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [bnf_pkg::CmdW-1:0]         cmd_i,
  input  wire logic [bnf_pkg::IndexW-1:0]       map_index_i,
  input  wire logic [bnf_pkg::ByteW-1:0]        map_byte_i,
  input  wire logic [bnf_pkg::BlockW-1:0]       hint_block_i,
  output logic                                  res_valid_o,
  input  wire logic                             res_ready_i,
  output bnf_pkg::res_t                         res_o,
  output logic                                  mem_we_o,
  output logic [((MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1)-1:0] mem_waddr_o,
  output logic [bnf_pkg::ByteW-1:0]             mem_wdata_o,
  output logic                                  mem_re_o,
  output logic [((MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1)-1:0] mem_raddr_o,
  input  wire logic [bnf_pkg::ByteW-1:0]        mem_rdata_i
);

  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int CW = $clog2(MAP_BYTES + 2);
  localparam int BW = AW + 3;
  localparam logic [CW-1:0] LastIss     = CW'(MAP_BYTES);
  localparam logic [AW-1:0] LastAddr    = AW'(MAP_BYTES - 1);
  localparam logic [31:0]   MapBytesW   = 32'(MAP_BYTES);
  localparam logic [31:0]   TotalBlocks = 32'(MAP_BYTES * 8);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]    state_q, state_d;
  bnf_pkg::res_t res_q, res_d;
  logic [AW-1:0] na_q, na_d;
  logic [CW-1:0] iss_q, iss_d;
  logic [2:0]    off_q, off_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic          pend_first_q, pend_first_d;
  logic          pend_last_q, pend_last_d;

  logic          idx_ok, hint_ok;
  logic [AW-1:0] start_byte;
  logic [2:0]    start_off;
  logic [7:0]    mask, cand, one_hot;
  logic [2:0]    bit_idx;
  logic          hit;
  logic [BW-1:0] blk_full;

  assign idx_ok     = {25'd0, map_index_i} < MapBytesW;
  assign hint_ok    = {22'd0, hint_block_i} < TotalBlocks;
  assign start_byte = hint_ok ? AW'(hint_block_i[9:3]) : '0;
  assign start_off  = hint_ok ? hint_block_i[2:0] : 3'd0;

  // First read of the start byte looks at bits from the offset up, the
  // final revisit after wrapping looks at the bits below it.
  always_comb begin
    if (pend_first_q) begin
      mask = 8'hFF << off_q;
    end else if (pend_last_q) begin
      mask = ~(8'hFF << off_q);
    end else begin
      mask = 8'hFF;
    end
  end

  assign cand    = mem_rdata_i & mask;
  assign one_hot = cand & (~cand + 8'd1);
  assign hit     = pend_q && (cand != 8'd0);

  always_comb begin
    bit_idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (cand[i]) begin
        bit_idx = 3'(i);
      end
    end
  end

  assign blk_full = {pend_addr_q, bit_idx};

  always_comb begin
    state_d      = state_q;
    res_d        = res_q;
    na_d         = na_q;
    iss_d        = iss_q;
    off_d        = off_q;
    pend_d       = pend_q;
    pend_addr_d  = pend_addr_q;
    pend_first_d = pend_first_q;
    pend_last_d  = pend_last_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = pend_addr_q;
    mem_wdata_o  = mem_rdata_i & ~one_hot;
    mem_re_o     = 1'b0;
    mem_raddr_o  = na_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d   = '0;
          state_d = S_OUT;
          case (cmd_i)
            bnf_pkg::CMD_WRITE: begin
              if (idx_ok) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = AW'(map_index_i);
                mem_wdata_o = map_byte_i;
              end
            end
            bnf_pkg::CMD_READ: begin
              if (idx_ok) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = AW'(map_index_i);
                state_d     = S_RD;
              end
            end
            bnf_pkg::CMD_ALLOC: begin
              mem_re_o     = 1'b1;
              mem_raddr_o  = start_byte;
              pend_d       = 1'b1;
              pend_addr_d  = start_byte;
              pend_first_d = 1'b1;
              pend_last_d  = 1'b0;
              na_d         = (start_byte == LastAddr) ? '0 : start_byte + 1'b1;
              iss_d        = CW'(1);
              off_d        = start_off;
              state_d      = S_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        res_d.read_byte = mem_rdata_i;
        state_d         = S_OUT;
      end
      S_SCAN: begin
        if (hit) begin
          // clear the found bit and stop issuing reads
          mem_we_o           = 1'b1;
          res_d.block_number = bnf_pkg::BlockW'(blk_full);
          pend_d             = 1'b0;
          state_d            = S_OUT;
        end else if (iss_q <= LastIss) begin
          mem_re_o     = 1'b1;
          pend_d       = 1'b1;
          pend_addr_d  = na_q;
          pend_first_d = 1'b0;
          pend_last_d  = (iss_q == LastIss);
          na_d         = (na_q == LastAddr) ? '0 : na_q + 1'b1;
          iss_d        = iss_q + 1'b1;
        end else begin
          res_d.failed = 1'b1;
          pend_d       = 1'b0;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q        <= res_d;
    na_q         <= na_d;
    iss_q        <= iss_d;
    off_q        <= off_d;
    pend_addr_q  <= pend_addr_d;
    pend_first_q <= pend_first_d;
    pend_last_q  <= pend_last_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_o       = res_q;

endmodule

`default_nettype wire

@@ hdl/bitmap_next_fit_allocator.sv @@
// Next-fit block allocator over a usage map held in one single-port-read RAM of
// MAP_BYTES bytes (bit set = block free). An allocation reads one map byte per
// cycle through the RAM read port, starting at the hint byte, wrapping at the
// end of the map and finally revisiting the hint byte: up to MAP_BYTES + 1
// reads. The map has no reset: load every byte before reading it or allocating.
// A new beat is taken once the previous result has moved into the output
// register, which holds it while the sink stalls.
`default_nettype none

module bitmap_next_fit_allocator #(
  parameter int MAP_BYTES = bnf_pkg::MAP_BYTES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [bnf_pkg::CmdW-1:0]     cmd_i,
  input  wire logic [bnf_pkg::IndexW-1:0]   map_index_i,
  input  wire logic [bnf_pkg::ByteW-1:0]    map_byte_i,
  input  wire logic [bnf_pkg::BlockW-1:0]   hint_block_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [bnf_pkg::BlockW-1:0]   block_number_o,
  output logic                              failed_o,
  output logic      [bnf_pkg::ByteW-1:0]    read_byte_o
);

  localparam int AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  logic                      mem_we, mem_re;
  logic [AW-1:0]             mem_waddr, mem_raddr;
  logic [bnf_pkg::ByteW-1:0] mem_wdata, mem_rdata;

  logic          res_valid, res_ready;
  bnf_pkg::res_t res;

  logic          out_valid_q, out_valid_d;
  bnf_pkg::res_t out_q;

  bnf_ram #(
    .WIDTH (bnf_pkg::ByteW),
    .DEPTH (MAP_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bnf_ctrl #(
    .MAP_BYTES (MAP_BYTES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .map_index_i  (map_index_i),
    .map_byte_i   (map_byte_i),
    .hint_block_i (hint_block_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  // Load the output register when it is empty or being drained this cycle.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign block_number_o = out_q.block_number;
  assign failed_o       = out_q.failed;
  assign read_byte_o    = out_q.read_byte;

endmodule

`default_nettype wire

@@ hdl/bnf_checker.sv @@
`default_nettype none

module bnf_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [bnf_pkg::BlockW-1:0]   block_number_o,
  input wire logic                         failed_o,
  input wire logic [bnf_pkg::ByteW-1:0]    read_byte_o
);

  // A failed allocation carries no block and no byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && failed_o |-> block_number_o == '0 && read_byte_o == '0)
    else $error("failed result carries payload");

  // A returned byte never comes with a block number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_byte_o != '0 |-> block_number_o == '0 && !failed_o)
    else $error("read byte mixed with allocation fields");

  // Only one beat is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second beat accepted while busy");

  // Hold a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(block_number_o)
      && $stable(failed_o) && $stable(read_byte_o))
    else $error("stalled result changed");

endmodule

bind bitmap_next_fit_allocator bnf_checker u_bnf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .block_number_o (block_number_o),
  .failed_o       (failed_o),
  .read_byte_o    (read_byte_o)
);

`default_nettype wire
